@@ design/duplex_byte_channel_pair_defines.svh @@
// ----------------------------------------------------------------------------
// duplex_byte_channel_pair_defines.svh
// Assertion macros used by dbcp_ctrl in the channel pair RTL.
// ----------------------------------------------------------------------------
`ifndef DUPLEX_BYTE_CHANNEL_PAIR_DEFINES_SVH
`define DUPLEX_BYTE_CHANNEL_PAIR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DBCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DBCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dbcp_pkg.sv @@
// ----------------------------------------------------------------------------
// dbcp_pkg
// Types, codes and ring helpers for the duplex byte channel pair.
// ----------------------------------------------------------------------------
package dbcp_pkg;

  localparam int RING_DEPTH      = 4096;
  localparam int PTR_W           = $clog2(RING_DEPTH);
  localparam int MAX_SLAVE_OPENS = 255;
  localparam int SO_W            = $clog2(MAX_SLAVE_OPENS + 1);
  localparam int COUNT_W         = 12;
  localparam int BYTE_W          = 8;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [SO_W-1:0]  opens_t;

  typedef enum logic [2:0] {
    REQ_OPEN_MASTER = 3'd0,
    REQ_OPEN_SLAVE  = 3'd1,
    REQ_CLOSE       = 3'd2,
    REQ_WRITE       = 3'd3,
    REQ_READ        = 3'd4,
    REQ_LOCK        = 3'd5,
    REQ_COUNT       = 3'd6,
    REQ_POLL        = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EOF         = 3'd1,
    ST_WOULD_BLOCK = 3'd2,
    ST_IO_ERROR    = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_NO_SPACE    = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_RDATA
  } fsm_t;

  // one ring memory port pair
  typedef struct packed {
    logic              we;
    ptr_t              waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    ptr_t              raddr;
  } mem_req_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ring_level(input ptr_t head, input ptr_t tail);
    logic [PTR_W:0] wrap;
    wrap = {1'b0, head} + (PTR_W+1)'(RING_DEPTH) - {1'b0, tail};
    ring_level = (head >= tail) ? head - tail : wrap[PTR_W-1:0];
  endfunction

endpackage

@@ design/dbcp_ring_ram.sv @@
// ----------------------------------------------------------------------------
// dbcp_ring_ram
// Simple dual-port byte memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module dbcp_ring_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/dbcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dbcp_ctrl
// Request decode, ring pointers, endpoint state and result registers.
// ----------------------------------------------------------------------------
`include "duplex_byte_channel_pair_defines.svh"

module dbcp_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_req_type,
  input  logic                       in_side,
  input  logic [dbcp_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_lock_value,
  input  logic                       in_want_in,
  input  logic                       in_want_out,
  output dbcp_pkg::mem_req_t         down_req,
  output dbcp_pkg::mem_req_t         up_req,
  input  logic [dbcp_pkg::BYTE_W-1:0] down_rdata,
  input  logic [dbcp_pkg::BYTE_W-1:0] up_rdata,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [dbcp_pkg::BYTE_W-1:0] out_read_byte,
  output logic [dbcp_pkg::COUNT_W-1:0] out_byte_count,
  output logic                       out_readable,
  output logic                       out_writable,
  output logic                       out_hangup
);
  import dbcp_pkg::*;

  fsm_t    state_r, state_nxt;
  ptr_t    down_head_r, down_head_nxt, down_tail_r, down_tail_nxt;
  ptr_t    up_head_r, up_head_nxt, up_tail_r, up_tail_nxt;
  logic    master_open_r, master_open_nxt;
  opens_t  slave_opens_r, slave_opens_nxt;
  logic    slave_locked_r, slave_locked_nxt;
  logic    pair_active_r, pair_active_nxt;
  logic    rd_side_r, rd_side_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic [BYTE_W-1:0]    read_byte_r, read_byte_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 readable_r, readable_nxt;
  logic                 writable_r, writable_nxt;
  logic                 hangup_r, hangup_nxt;

  req_t    req;
  logic    acc;
  logic    peer_open;
  ptr_t    tx_head, tx_tail, rx_head, rx_tail;
  ptr_t    rx_used;
  logic    tx_full, rx_empty;

  assign req       = req_t'(in_req_type);
  assign acc       = start && (state_r == FSM_IDLE);
  assign peer_open = in_side ? master_open_r : (slave_opens_r != '0);

  // slave transmits on the up ring and receives on the down ring
  assign tx_head  = in_side ? up_head_r   : down_head_r;
  assign tx_tail  = in_side ? up_tail_r   : down_tail_r;
  assign rx_head  = in_side ? down_head_r : up_head_r;
  assign rx_tail  = in_side ? down_tail_r : up_tail_r;
  assign rx_used  = ring_level(rx_head, rx_tail);
  assign rx_empty = (rx_head == rx_tail);
  assign tx_full  = (ring_level(tx_head, tx_tail) == PTR_W'(RING_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= FSM_IDLE;
      down_head_r    <= '0;
      down_tail_r    <= '0;
      up_head_r      <= '0;
      up_tail_r      <= '0;
      master_open_r  <= 1'b0;
      slave_opens_r  <= '0;
      slave_locked_r <= 1'b1;
      pair_active_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      down_head_r    <= down_head_nxt;
      down_tail_r    <= down_tail_nxt;
      up_head_r      <= up_head_nxt;
      up_tail_r      <= up_tail_nxt;
      master_open_r  <= master_open_nxt;
      slave_opens_r  <= slave_opens_nxt;
      slave_locked_r <= slave_locked_nxt;
      pair_active_r  <= pair_active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_side_r   <= rd_side_nxt;
    status_r    <= status_nxt;
    read_byte_r <= read_byte_nxt;
    count_r     <= count_nxt;
    readable_r  <= readable_nxt;
    writable_r  <= writable_nxt;
    hangup_r    <= hangup_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    down_head_nxt    = down_head_r;
    down_tail_nxt    = down_tail_r;
    up_head_nxt      = up_head_r;
    up_tail_nxt      = up_tail_r;
    master_open_nxt  = master_open_r;
    slave_opens_nxt  = slave_opens_r;
    slave_locked_nxt = slave_locked_r;
    pair_active_nxt  = pair_active_r;
    rd_side_nxt      = rd_side_r;

    out_valid_nxt = 1'b0;
    status_nxt    = ST_OK;
    read_byte_nxt = '0;
    count_nxt     = '0;
    readable_nxt  = 1'b0;
    writable_nxt  = 1'b0;
    hangup_nxt    = 1'b0;

    down_req = '0;
    up_req   = '0;

    unique case (state_r)
      FSM_RDATA: begin
        // read data arrives in the cycle after the address
        out_valid_nxt = 1'b1;
        read_byte_nxt = rd_side_r ? down_rdata : up_rdata;
        state_nxt     = FSM_IDLE;
      end

      FSM_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          unique case (req) inside
            REQ_OPEN_MASTER: begin
              if (pair_active_r) begin
                status_nxt = ST_NO_SPACE;
              end else begin
                down_head_nxt    = '0;
                down_tail_nxt    = '0;
                up_head_nxt      = '0;
                up_tail_nxt      = '0;
                master_open_nxt  = 1'b1;
                slave_opens_nxt  = '0;
                slave_locked_nxt = 1'b1;
                pair_active_nxt  = 1'b1;
              end
            end

            REQ_OPEN_SLAVE: begin
              if (!pair_active_r || !master_open_r) begin
                status_nxt = ST_NOT_FOUND;
              end else if (slave_locked_r) begin
                status_nxt = ST_IO_ERROR;
              end else if (slave_opens_r < SO_W'(MAX_SLAVE_OPENS)) begin
                slave_opens_nxt = slave_opens_r + 1'b1;
              end
            end

            REQ_CLOSE: begin
              if (pair_active_r) begin
                if (in_side) begin
                  if (slave_opens_r != '0) begin
                    slave_opens_nxt = slave_opens_r - 1'b1;
                  end
                end else begin
                  master_open_nxt = 1'b0;
                end
                if (!master_open_nxt && (slave_opens_nxt == '0)) begin
                  pair_active_nxt = 1'b0;
                end
              end
            end

            REQ_WRITE, REQ_READ, REQ_LOCK, REQ_COUNT, REQ_POLL: begin
              if (!pair_active_r) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                case (req)
                  REQ_WRITE: begin
                    if (!peer_open) begin
                      status_nxt = ST_IO_ERROR;
                    end else if (tx_full) begin
                      status_nxt = ST_WOULD_BLOCK;
                    end else if (in_side) begin
                      up_req.we    = 1'b1;
                      up_req.waddr = up_head_r;
                      up_req.wdata = in_data_byte;
                      up_head_nxt  = ring_next(up_head_r);
                    end else begin
                      down_req.we    = 1'b1;
                      down_req.waddr = down_head_r;
                      down_req.wdata = in_data_byte;
                      down_head_nxt  = ring_next(down_head_r);
                    end
                  end

                  REQ_READ: begin
                    if (rx_empty && !peer_open) begin
                      status_nxt = ST_EOF;
                    end else if (rx_empty) begin
                      status_nxt = ST_WOULD_BLOCK;
                    end else begin
                      out_valid_nxt = 1'b0;
                      state_nxt     = FSM_RDATA;
                      rd_side_nxt   = in_side;
                      if (in_side) begin
                        down_req.re   = 1'b1;
                        down_req.raddr = down_tail_r;
                        down_tail_nxt = ring_next(down_tail_r);
                      end else begin
                        up_req.re   = 1'b1;
                        up_req.raddr = up_tail_r;
                        up_tail_nxt = ring_next(up_tail_r);
                      end
                    end
                  end

                  REQ_LOCK: begin
                    if (in_side) begin
                      status_nxt = ST_IO_ERROR;
                    end else begin
                      slave_locked_nxt = in_lock_value;
                    end
                  end

                  REQ_COUNT: begin
                    count_nxt = COUNT_W'(rx_used);
                  end

                  default: begin
                    readable_nxt = (!rx_empty || !peer_open) && in_want_in;
                    writable_nxt = !tx_full && peer_open && in_want_out;
                    hangup_nxt   = !peer_open;
                  end
                endcase
              end
            end
          endcase
        end
      end
    endcase
  end

  assign busy           = (state_r == FSM_RDATA);
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_byte  = read_byte_r;
  assign out_byte_count = count_r;
  assign out_readable   = readable_r;
  assign out_writable   = writable_r;
  assign out_hangup     = hangup_r;

  `DBCP_ASSERT_NXT(a_rdata_one_cycle, busy, !busy && out_valid, "read wait overran")
  `DBCP_ASSERT_IMP(a_free_pair_closed, !pair_active_r,
                   !master_open_r && (slave_opens_r == '0), "free pair has open side")
  `DBCP_ASSERT_IMP(a_byte_only_on_ok, out_valid && (out_status != ST_OK),
                   out_read_byte == '0, "byte on failed request")
  `DBCP_ASSERT_IMP(a_one_ring_read, down_req.re || up_req.re,
                   !(down_req.re && up_req.re) && acc, "stray ring read")
  `DBCP_ASSERT_IMP(a_slave_cap, 1'b1, slave_opens_r <= SO_W'(MAX_SLAVE_OPENS),
                   "slave opens over cap")

endmodule

@@ design/duplex_byte_channel_pair.sv @@
// ----------------------------------------------------------------------------
// duplex_byte_channel_pair
// Master/slave endpoint pair joined by two byte rings, one per direction.
// ----------------------------------------------------------------------------
// One request is taken per start beat while busy is low. Every request but a
// successful read returns its result in the cycle after acceptance, and a new
// request can be accepted in that same cycle, so such requests run at one per
// cycle. A read that takes a byte holds busy in the RDATA state while the ring
// memory returns the data from its read register, and its result follows from
// that state. Results are strobed by out_valid for one cycle each and cannot
// be stalled; they come back in request order. Ring contents are not cleared
// at reset; bytes are only ever read after they were written.
// ----------------------------------------------------------------------------
module duplex_byte_channel_pair (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_req_type,
  input  logic                          in_side,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_lock_value,
  input  logic                          in_want_in,
  input  logic                          in_want_out,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [7:0]                    out_read_byte,
  output logic [11:0]                   out_byte_count,
  output logic                          out_readable,
  output logic                          out_writable,
  output logic                          out_hangup
);
  import dbcp_pkg::*;

  mem_req_t          down_req, up_req;
  logic [BYTE_W-1:0] down_rdata, up_rdata;

  dbcp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_side        (in_side),
    .in_data_byte   (in_data_byte),
    .in_lock_value  (in_lock_value),
    .in_want_in     (in_want_in),
    .in_want_out    (in_want_out),
    .down_req       (down_req),
    .up_req         (up_req),
    .down_rdata     (down_rdata),
    .up_rdata       (up_rdata),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_byte  (out_read_byte),
    .out_byte_count (out_byte_count),
    .out_readable   (out_readable),
    .out_writable   (out_writable),
    .out_hangup     (out_hangup)
  );

  // master to slave
  dbcp_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (BYTE_W)
  ) u_down_ram (
    .clk   (clk),
    .we    (down_req.we),
    .waddr (down_req.waddr),
    .wdata (down_req.wdata),
    .re    (down_req.re),
    .raddr (down_req.raddr),
    .rdata (down_rdata)
  );

  // slave to master
  dbcp_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (BYTE_W)
  ) u_up_ram (
    .clk   (clk),
    .we    (up_req.we),
    .waddr (up_req.waddr),
    .wdata (up_req.wdata),
    .re    (up_req.re),
    .raddr (up_req.raddr),
    .rdata (up_rdata)
  );

endmodule
